>>> src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rv32_pkg.sv
package rv32_pkg;

    localparam int NUM_REGS = 32;
    localparam int REG_IDX_W = $clog2(NUM_REGS);

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_COND_BR = 7'h63;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_pc;      // load pc from start address
        logic latch_instr;  // capture instruction
        logic read_regs;    // read register file operands
        logic exec;         // compute result
        logic div_start;    // launch divider
        logic commit;       // write back and present result
    } rv32_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic needs_div;
        logic div_done;
    } rv32_stat_t;

endpackage

>>> src/rv32_div.sv
// Radix-2 restoring divider on magnitudes, 32 steps
module rv32_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    logic [31:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg[31:0], quo_reg[31]};
    assign diff = shifted - {1'b0, dvs_reg};

    // Shift one quotient bit a cycle while busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (diff[32])
                begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                else
                begin
                    rem_reg <= diff;
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[31:0];
endmodule

>>> src/rv32_datapath.sv
module rv32_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  rv32_pkg::rv32_cmd_t cmd,
    output rv32_pkg::rv32_stat_t stat,
    input  logic [31:0]         start_address,
    input  logic [31:0]         instruction,
    output logic [31:0]         instr_pc,
    output logic [31:0]         next_pc,
    output logic                branch_taken,
    output logic                reg_written,
    output logic [4:0]          dest_index,
    output logic [31:0]         dest_value,
    output logic                status
);
    import rv32_pkg::*;

    logic [31:0] regs [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [31:0] pc_reg;
    logic [31:0] ins_reg;
    logic [31:0] a_reg, b_reg;
    logic [31:0] val_reg, next_reg;
    logic        wr_reg, taken_reg, bad_reg;
    logic [63:0] prod_reg;
    logic        mul_reg;
    logic        mhi_reg;
    logic        div_ovf_reg, div_zero_reg;

    logic [6:0] op, f7;
    logic [2:0] f3;
    logic [4:0] rd, rs1, rs2, shamt;
    logic [31:0] immi, immb, immj, immu, seq;
    logic [31:0] val_c, next_c;
    logic        wr_c, taken_c, bad_c, cond, muldiv;
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod_c;
    logic [31:0] na, nb, q_c, r_c;
    logic        div_done;
    logic [31:0] quo, rem;

    assign op    = ins_reg[6:0];
    assign rd    = ins_reg[11:7];
    assign f3    = ins_reg[14:12];
    assign rs1   = ins_reg[19:15];
    assign rs2   = ins_reg[24:20];
    assign f7    = ins_reg[31:25];
    assign shamt = ins_reg[24:20];
    assign immi  = {{20{ins_reg[31]}}, ins_reg[31:20]};
    assign immb  = {{19{ins_reg[31]}}, ins_reg[31], ins_reg[7], ins_reg[30:25],
                    ins_reg[11:8], 1'b0};
    assign immj  = {{11{ins_reg[31]}}, ins_reg[31], ins_reg[19:12], ins_reg[20],
                    ins_reg[30:21], 1'b0};
    assign immu  = {ins_reg[31:12], 12'h000};
    assign seq   = pc_reg + 32'd4;
    assign muldiv = (op == OP_REG) && (f7 == F7_MULDIV);

    // Multiply operand extension by funct3
    assign ma = {(f3 != 3'd3) & a_reg[31], a_reg};
    assign mb = {(f3 == 3'd1) & b_reg[31], b_reg};
    assign prod_c = ma * mb;

    // Divider operand magnitudes
    assign na = (!f3[0] && a_reg[31]) ? 32'd0 - a_reg : a_reg;
    assign nb = (!f3[0] && b_reg[31]) ? 32'd0 - b_reg : b_reg;

    rv32_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (na),
        .divisor   (nb),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    assign stat = {muldiv && f3[2], div_done};

    // Sign-correct divider results
    assign q_c = (!f3[0] && (a_reg[31] ^ b_reg[31])) ? 32'd0 - quo : quo;
    assign r_c = (!f3[0] && a_reg[31]) ? 32'd0 - rem : rem;

    // Decode and execute everything but multiply and divide
    always_comb
    begin
        val_c = '0;
        next_c = seq;
        wr_c = 1'b0;
        taken_c = 1'b0;
        bad_c = 1'b0;
        cond = 1'b0;
        unique case (op)
            OP_LUI:
            begin
                val_c = immu;
                wr_c = 1'b1;
            end
            OP_AUIPC:
            begin
                val_c = pc_reg + immu;
                wr_c = 1'b1;
            end
            OP_JAL:
            begin
                val_c = seq;
                wr_c = 1'b1;
                next_c = pc_reg + immj;
                taken_c = 1'b1;
            end
            OP_JALR:
            begin
                if (f3 != 3'd0)
                    bad_c = 1'b1;
                else
                begin
                    val_c = seq;
                    wr_c = 1'b1;
                    next_c = (a_reg + immi) & 32'hFFFF_FFFE;
                    taken_c = 1'b1;
                end
            end
            OP_COND_BR:
            begin
                unique case (f3)
                    3'd0: cond = a_reg == b_reg;
                    3'd1: cond = a_reg != b_reg;
                    3'd4: cond = $signed(a_reg) < $signed(b_reg);
                    3'd5: cond = $signed(a_reg) >= $signed(b_reg);
                    3'd6: cond = a_reg < b_reg;
                    3'd7: cond = a_reg >= b_reg;
                    default: bad_c = 1'b1;
                endcase
                if (cond)
                begin
                    next_c = pc_reg + immb;
                    taken_c = 1'b1;
                end
            end
            OP_IMM:
            begin
                wr_c = 1'b1;
                unique case (f3)
                    3'd0: val_c = a_reg + immi;
                    3'd2: val_c = {31'd0, $signed(a_reg) < $signed(immi)};
                    3'd3: val_c = {31'd0, a_reg < immi};
                    3'd4: val_c = a_reg ^ immi;
                    3'd6: val_c = a_reg | immi;
                    3'd7: val_c = a_reg & immi;
                    3'd1:
                    begin
                        if (f7 != F7_BASE) bad_c = 1'b1;
                        else val_c = a_reg << shamt;
                    end
                    default:
                    begin
                        if (f7 == F7_BASE) val_c = a_reg >> shamt;
                        else if (f7 == F7_ALT) val_c = $unsigned($signed(a_reg) >>> shamt);
                        else bad_c = 1'b1;
                    end
                endcase
            end
            OP_REG:
            begin
                wr_c = 1'b1;
                if (f7 == F7_MULDIV)
                    val_c = '0;
                else if (f7 == F7_ALT)
                begin
                    if (f3 == 3'd0) val_c = a_reg - b_reg;
                    else if (f3 == 3'd5)
                        val_c = $unsigned($signed(a_reg) >>> b_reg[4:0]);
                    else bad_c = 1'b1;
                end
                else if (f7 != F7_BASE)
                    bad_c = 1'b1;
                else
                begin
                    unique case (f3)
                        3'd0: val_c = a_reg + b_reg;
                        3'd1: val_c = a_reg << b_reg[4:0];
                        3'd2: val_c = {31'd0, $signed(a_reg) < $signed(b_reg)};
                        3'd3: val_c = {31'd0, a_reg < b_reg};
                        3'd4: val_c = a_reg ^ b_reg;
                        3'd5: val_c = a_reg >> b_reg[4:0];
                        3'd6: val_c = a_reg | b_reg;
                        default: val_c = a_reg & b_reg;
                    endcase
                end
            end
            default: bad_c = 1'b1;
        endcase
        if (bad_c)
        begin
            wr_c = 1'b0;
            taken_c = 1'b0;
            next_c = seq;
            val_c = '0;
        end
        if (rd == 5'd0 || 32'(rd) >= 32'(NUM_REGS))
            wr_c = 1'b0;
    end

    // Register file storage
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_reg)
            regs[rd[REG_IDX_W-1:0]] <= (mul_reg ? (mhi_reg ? prod_reg[63:32]
                                                           : prod_reg[31:0]) : val_reg);
    end

    // Entry valid bits and pc
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            pc_reg <= '0;
        end
        else
        begin
            if (cmd.load_pc)
                pc_reg <= start_address;
            else if (cmd.commit)
                pc_reg <= next_reg;
            if (cmd.commit && wr_reg)
                valid_reg[rd[REG_IDX_W-1:0]] <= 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_instr)
            ins_reg <= instruction;
        if (cmd.read_regs)
        begin
            a_reg <= (rs1 != 5'd0 && 32'(rs1) < 32'(NUM_REGS) && valid_reg[rs1[REG_IDX_W-1:0]])
                     ? regs[rs1[REG_IDX_W-1:0]] : 32'd0;
            b_reg <= (rs2 != 5'd0 && 32'(rs2) < 32'(NUM_REGS) && valid_reg[rs2[REG_IDX_W-1:0]])
                     ? regs[rs2[REG_IDX_W-1:0]] : 32'd0;
        end
        if (cmd.exec)
        begin
            val_reg <= val_c;
            next_reg <= next_c;
            wr_reg <= wr_c;
            taken_reg <= taken_c;
            bad_reg <= bad_c;
            mul_reg <= muldiv && !f3[2] && !bad_c;
            mhi_reg <= f3 != 3'd0;
            prod_reg <= prod_c[63:0];
            div_zero_reg <= b_reg == 32'd0;
            div_ovf_reg <= a_reg == 32'h8000_0000 && b_reg == 32'hFFFF_FFFF;
        end
        if (div_done)
        begin
            if (div_zero_reg)
                val_reg <= f3[1] ? a_reg : 32'hFFFF_FFFF;
            else if (div_ovf_reg && !f3[0])
                val_reg <= f3[1] ? 32'd0 : 32'h8000_0000;
            else
                val_reg <= f3[1] ? r_c : q_c;
        end
        if (cmd.commit)
        begin
            instr_pc <= pc_reg;
            next_pc <= next_reg;
            branch_taken <= taken_reg;
            reg_written <= wr_reg;
            dest_index <= wr_reg ? rd : 5'd0;
            dest_value <= wr_reg ? (mul_reg ? (mhi_reg ? prod_reg[63:32] : prod_reg[31:0])
                                            : val_reg) : 32'd0;
            status <= bad_reg;
        end
    end
endmodule

>>> src/rv32_ctrl.sv
module rv32_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  rv32_pkg::rv32_stat_t stat,
    output rv32_pkg::rv32_cmd_t  cmd
);
    import rv32_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_DIVWAIT, ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   ov_reg;
    logic   cfg_go;

    // Take items only when idle and no start address write is waiting;
    // take start address writes only when nothing is in flight
    assign in_ready  = state_reg == ST_IDLE && !cfg_valid;
    assign cfg_ready = state_reg == ST_IDLE && !ov_reg;
    assign out_valid = ov_reg;
    assign cfg_go    = cfg_valid && cfg_ready;

    always_comb
    begin
        cmd = '0;
        cmd.load_pc     = cfg_go;
        cmd.latch_instr = in_valid && in_ready;
        cmd.read_regs   = state_reg == ST_READ;
        cmd.exec        = state_reg == ST_EXEC;
        cmd.div_start   = state_reg == ST_DIV;
        cmd.commit      = state_reg == ST_COMMIT && (!ov_reg || out_ready);
    end

    // Sequence one item through read, execute, optional divide and commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
                ov_reg <= 1'b1;
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:    if (in_valid && in_ready) state_reg <= ST_READ;
                ST_READ:    state_reg <= ST_EXEC;
                ST_EXEC:    state_reg <= stat.needs_div ? ST_DIV : ST_COMMIT;
                ST_DIV:     state_reg <= ST_DIVWAIT;
                ST_DIVWAIT: if (stat.div_done) state_reg <= ST_COMMIT;
                ST_COMMIT:  if (cmd.commit) state_reg <= ST_IDLE;
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> src/rv32im_integer_execute_core.sv
// RV32IM execute core: one instruction item at a time.
// Steps: read operands, execute, run the 32-step divider for divide and
// remainder, then commit; the result is registered at commit.
// A new item is taken only once the last one has committed; while a result
// waits for out_ready, the next item's commit is held.
// Reset: pc 0, register file reads zero, no result pending.
module rv32im_integer_execute_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instruction,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] start_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] instr_pc,
    output logic [31:0] next_pc,
    output logic        branch_taken,
    output logic        reg_written,
    output logic [4:0]  dest_index,
    output logic [31:0] dest_value,
    output logic        status
);
    import rv32_pkg::*;

    rv32_cmd_t  cmd;
    rv32_stat_t stat;

    rv32_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rv32_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .start_address (start_address),
        .instruction   (instruction),
        .instr_pc      (instr_pc),
        .next_pc       (next_pc),
        .branch_taken  (branch_taken),
        .reg_written   (reg_written),
        .dest_index    (dest_index),
        .dest_value    (dest_value),
        .status        (status)
    );
endmodule

>>> src/rv32_checker.sv
`include "assert_macros.svh"

module rv32_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        reg_written,
    input logic [4:0]  dest_index,
    input logic [31:0] dest_value,
    input logic        status,
    input logic        branch_taken
);
    `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "second item taken while busy")
    `ASSERT_IMPL(a_no_idx, clk, rst_n, out_valid && !reg_written, dest_index == 5'd0 && dest_value == 32'd0, "payload without write")
    `ASSERT_IMPL(a_bad, clk, rst_n, out_valid && status, !reg_written && !branch_taken, "unhandled item acted")
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(dest_value), "result dropped")
endmodule

bind rv32im_integer_execute_core rv32_checker u_chk (.*);

>>> sim/tb_top.sv
module tb_top;
    import rv32_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] instruction;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] start_address;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] instr_pc;
    logic [31:0] next_pc;
    logic        branch_taken;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        status;

    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] npc;
        logic        taken;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        unhandled;
    } retire_t;

    localparam int STALL_LIMIT = 2000;

    // Shadow core: register file, pc, and the queue of retire records to come
    class retire_board;
        logic [31:0] regs [32];
        logic [31:0] pc;
        retire_t     pending [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc = '0;
            errors = 0;
        endfunction

        function logic [31:0] rreg(logic [4:0] i);
            return (i != 0 && i < NUM_REGS) ? regs[i] : 32'h0;
        endfunction

        function logic [31:0] muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
            logic signed [63:0] p;
            logic [63:0]        u;
            logic [31:0]        na;
            logic [31:0]        nb;
            case (f3)
                3'd0: return a * b;
                3'd1:
                begin
                    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    return p[63:32];
                end
                3'd2:
                begin
                    u = {{32{a[31]}}, a} * {32'h0, b};
                    return u[63:32];
                end
                3'd3:
                begin
                    u = {32'h0, a} * {32'h0, b};
                    return u[63:32];
                end
                3'd5: return (b == 0) ? 32'hFFFF_FFFF : a / b;
                3'd7: return (b == 0) ? a : a % b;
                default:
                begin
                    if (b == 0) return (f3 == 3'd4) ? 32'hFFFF_FFFF : a;
                    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                        return (f3 == 3'd4) ? 32'h8000_0000 : 32'h0;
                    na = a[31] ? -a : a;
                    nb = b[31] ? -b : b;
                    if (f3 == 3'd4) return (a[31] ^ b[31]) ? -(na / nb) : na / nb;
                    return a[31] ? -(na % nb) : na % nb;
                end
            endcase
        endfunction

        // Execute one accepted instruction and queue its retire record
        function void note_instr(logic [31:0] ins);
            retire_t     r;
            logic [6:0]  op;
            logic [6:0]  f7;
            logic [2:0]  f3;
            logic [4:0]  rd;
            logic [4:0]  sh;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] immi;
            logic [31:0] immb;
            logic [31:0] immj;
            logic [31:0] immu;
            logic [31:0] val;
            logic [31:0] nxt;
            logic        writes;
            logic        taken;
            logic        bad;
            logic        cond;
            op = ins[6:0];
            rd = ins[11:7];
            f3 = ins[14:12];
            f7 = ins[31:25];
            sh = ins[24:20];
            a = rreg(ins[19:15]);
            b = rreg(ins[24:20]);
            immi = {{20{ins[31]}}, ins[31:20]};
            immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            immu = {ins[31:12], 12'h0};
            nxt = pc + 4;
            val = '0;
            writes = 0;
            taken = 0;
            bad = 0;
            cond = 0;
            case (op)
                OP_LUI:
                begin
                    val = immu;
                    writes = 1;
                end
                OP_AUIPC:
                begin
                    val = pc + immu;
                    writes = 1;
                end
                OP_JAL:
                begin
                    val = pc + 4;
                    writes = 1;
                    nxt = pc + immj;
                    taken = 1;
                end
                OP_JALR:
                begin
                    if (f3 != 0) bad = 1;
                    else
                    begin
                        val = pc + 4;
                        writes = 1;
                        nxt = (a + immi) & 32'hFFFF_FFFE;
                        taken = 1;
                    end
                end
                OP_COND_BR:
                begin
                    case (f3)
                        3'd0: cond = a == b;
                        3'd1: cond = a != b;
                        3'd4: cond = $signed(a) < $signed(b);
                        3'd5: cond = $signed(a) >= $signed(b);
                        3'd6: cond = a < b;
                        3'd7: cond = a >= b;
                        default: bad = 1;
                    endcase
                    if (!bad && cond)
                    begin
                        nxt = pc + immb;
                        taken = 1;
                    end
                end
                OP_IMM:
                begin
                    writes = 1;
                    case (f3)
                        3'd0: val = a + immi;
                        3'd2: val = ($signed(a) < $signed(immi)) ? 1 : 0;
                        3'd3: val = (a < immi) ? 1 : 0;
                        3'd4: val = a ^ immi;
                        3'd6: val = a | immi;
                        3'd7: val = a & immi;
                        3'd1:
                            if (f7 != F7_BASE) bad = 1;
                            else val = a << sh;
                        default:
                            if (f7 == F7_BASE) val = a >> sh;
                            else if (f7 == F7_ALT) val = $signed(a) >>> sh;
                            else bad = 1;
                    endcase
                end
                OP_REG:
                begin
                    writes = 1;
                    if (f7 == F7_MULDIV) val = muldiv(f3, a, b);
                    else if (f7 == F7_ALT)
                    begin
                        if (f3 == 3'd0) val = a - b;
                        else if (f3 == 3'd5) val = $signed(a) >>> b[4:0];
                        else bad = 1;
                    end
                    else if (f7 != F7_BASE) bad = 1;
                    else
                        case (f3)
                            3'd0: val = a + b;
                            3'd1: val = a << b[4:0];
                            3'd2: val = ($signed(a) < $signed(b)) ? 1 : 0;
                            3'd3: val = (a < b) ? 1 : 0;
                            3'd4: val = a ^ b;
                            3'd5: val = a >> b[4:0];
                            3'd6: val = a | b;
                            default: val = a & b;
                        endcase
                end
                default: bad = 1;
            endcase
            if (bad)
            begin
                writes = 0;
                taken = 0;
                nxt = pc + 4;
                val = '0;
            end
            if (writes && (rd == 0 || rd >= NUM_REGS)) writes = 0;
            if (writes) regs[rd] = val;
            r.pc = pc;
            r.npc = nxt;
            r.taken = taken;
            r.wr = writes;
            r.rd = writes ? rd : 5'd0;
            r.val = writes ? val : 32'h0;
            r.unhandled = bad;
            pc = nxt;
            pending.push_back(r);
        endfunction

        function void check_retire(retire_t got);
            retire_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected retire %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("retire mismatch: pc exp %h got %h, npc exp %h got %h, tk %b/%b, wr %b/%b, rd %0d/%0d, val %h/%h, st %b/%b",
                        want.pc, got.pc, want.npc, got.npc, want.taken, got.taken,
                        want.wr, got.wr, want.rd, got.rd, want.val, got.val,
                        want.unhandled, got.unhandled);
            end
        endfunction
    endclass

    retire_board board;
    int          idle_cycles;
    bit          sending_done;

    rv32im_integer_execute_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .instruction(instruction),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .start_address(start_address),
        .out_valid(out_valid), .out_ready(out_ready),
        .instr_pc(instr_pc), .next_pc(next_pc), .branch_taken(branch_taken),
        .reg_written(reg_written), .dest_index(dest_index), .dest_value(dest_value),
        .status(status)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Check retires and count cycles with no handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_retire({instr_pc, next_pc, branch_taken, reg_written,
                                    dest_index, dest_value, status});
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Drain side with random out_ready stalls per item
    initial
    begin
        int w;
        out_ready = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (w > 0)
            begin
                out_ready <= 0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Hold valid across back-to-back items; drop it only before a gap
    task automatic send_instr(logic [31:0] ins, bit no_gap);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 9);
        if (w > 0)
        begin
            in_valid <= 0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1;
        instruction <= ins;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_instr(ins);
    endtask

    task automatic write_start(logic [31:0] addr);
        cfg_valid <= 1;
        start_address <= addr;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.pc = addr;
        cfg_valid <= 0;
    endtask

    task automatic drain;
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [31:0] r_type(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                           logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    // Mostly well-formed instructions over a small register window
    function automatic logic [31:0] rand_instr();
        logic [31:0] ins;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        int          k;
        ins = $urandom;
        rd = $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
        rs1 = 5'($urandom_range(0, 7));
        rs2 = 5'($urandom_range(0, 7));
        f3 = 3'($urandom);
        k = $urandom_range(0, 19);
        case (k)
            0: ins = {ins[31:12], rd, OP_LUI};
            1: ins = {ins[31:12], rd, OP_AUIPC};
            2: ins = {ins[31:12], rd, OP_JAL};
            3: ins = {ins[31:20], rs1, ($urandom_range(0, 7) == 0) ? f3 : 3'd0, rd, OP_JALR};
            4, 5: ins = {ins[31:25], rs2, rs1, f3, ins[11:7], OP_COND_BR};
            6, 7, 8, 9:
                if (f3 == 3'd1 || f3 == 3'd5)
                    ins = {($urandom_range(0, 7) == 0) ? ins[31:25]
                           : (($urandom_range(0, 1) && f3 == 3'd5) ? F7_ALT : F7_BASE),
                           ins[24:20], rs1, f3, rd, OP_IMM};
                else
                    ins = {ins[31:20], rs1, f3, rd, OP_IMM};
            10, 11, 12, 13:
                ins = r_type(($urandom_range(0, 9) == 0) ? ins[31:25]
                             : ($urandom_range(0, 1) ? F7_BASE : F7_ALT),
                             rs2, rs1, f3, rd, OP_REG);
            14, 15, 16: ins = r_type(F7_MULDIV, rs2, rs1, f3, rd, OP_REG);
            17: ins = {ins[31:7], ins[6:2], 2'b11};
            default: ;
        endcase
        return ins;
    endfunction

    initial
    begin
        logic [31:0] dir [$];
        int          n;
        board = new();
        rst_n = 0;
        in_valid = 0;
        instruction = '0;
        cfg_valid = 0;
        start_address = '0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Load extreme operands, then hit muldiv, shift and jump cases
        dir = '{
            {20'h80000, 5'd1, OP_LUI},
            {12'hFFF, 5'd0, 3'd0, 5'd2, OP_IMM},
            {12'hFFF, 5'd1, 3'd0, 5'd3, OP_IMM},
            r_type(F7_MULDIV, 5'd2, 5'd1, 3'd4, 5'd4, OP_REG),
            r_type(F7_MULDIV, 5'd2, 5'd1, 3'd6, 5'd5, OP_REG),
            r_type(F7_MULDIV, 5'd0, 5'd1, 3'd4, 5'd6, OP_REG),
            r_type(F7_MULDIV, 5'd0, 5'd1, 3'd5, 5'd6, OP_REG),
            r_type(F7_MULDIV, 5'd0, 5'd1, 3'd6, 5'd6, OP_REG),
            r_type(F7_MULDIV, 5'd0, 5'd1, 3'd7, 5'd6, OP_REG),
            r_type(F7_MULDIV, 5'd2, 5'd1, 3'd1, 5'd7, OP_REG),
            r_type(F7_MULDIV, 5'd2, 5'd1, 3'd2, 5'd7, OP_REG),
            r_type(F7_MULDIV, 5'd2, 5'd1, 3'd3, 5'd7, OP_REG),
            {F7_ALT, 5'd31, 5'd1, 3'd5, 5'd8, OP_IMM},
            {F7_BASE, 5'd31, 5'd1, 3'd5, 5'd8, OP_IMM},
            {7'h40, 5'd1, 5'd1, 3'd1, 5'd8, OP_IMM},
            r_type(F7_ALT, 5'd2, 5'd1, 3'd0, 5'd0, OP_REG),
            {12'hFFF, 5'd1, 3'd0, 5'd9, OP_JALR},
            {12'h001, 5'd1, 3'd1, 5'd9, OP_JALR},
            {7'h7F, 5'd2, 5'd1, 3'd2, 5'h1F, OP_COND_BR},
            {7'h7F, 5'd2, 5'd1, 3'd4, 5'h1F, OP_COND_BR},
            {20'hFFFFF, 5'd10, OP_JAL},
            {20'hFFFFF, 5'd11, OP_AUIPC},
            32'h0000_2003,
            32'hFFFF_FFFF,
            32'h0000_0000
        };
        foreach (dir[i]) send_instr(dir[i], 0);
        drain();

        // Phase settings include both start-address extremes
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_start(32'hFFFF_FFF8);
                1: write_start(32'h0);
                2: write_start(32'hFFFF_FFFF);
                default: write_start($urandom);
            endcase
            n = 200;
            for (int k = 0; k < n; k++)
            begin
                send_instr(rand_instr(), $urandom_range(0, 4) == 0);
                if (k == 100 && ph == 1)
                begin
                    in_valid <= 0;
                    while (board.pending.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
